// ===== rtl/core/glac_pkg.sv =====
// Shared types and constants for the G-code line assembler with XOR checksum.
package glac_pkg;

  localparam int unsigned LINE_BYTES_DEF = 256;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_N = 8'h4E;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_ERROR  = 8'h7F;

  localparam logic [8:0] DECL_SUM_MAX = 9'd256;

  typedef enum logic {
    KIND_CHAR    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    VERD_ACCEPT   = 3'd0,
    VERD_RESEND   = 3'd1,
    VERD_BAD_SUM  = 3'd2,
    VERD_MISSING  = 3'd3,
    VERD_OVERFLOW = 3'd4
  } verdict_e;

  typedef struct packed {
    kind_e      item_kind;
    logic [7:0] char_value;
    logic [7:0] char_position;
    verdict_e   verdict;
    logic [31:0] line_number;
    logic [8:0] line_length;
    logic [7:0] indent;
  } res_t;

endpackage

// ===== rtl/core/glac_if.sv =====
// Valid/ready channel interfaces for text bytes in and line items out.
interface glac_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       top_level;

  modport source (output valid, output rx_byte, output top_level, input ready);
  modport sink   (input valid, input rx_byte, input top_level, output ready);
endinterface

interface glac_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  char_value;
  logic [7:0]  char_position;
  logic [2:0]  verdict;
  logic [31:0] line_number;
  logic [8:0]  line_length;
  logic [7:0]  indent;

  modport source (output valid, output item_kind, output char_value, output char_position,
                  output verdict, output line_number, output line_length, output indent,
                  input ready);
  modport sink   (input valid, input item_kind, input char_value, input char_position,
                  input verdict, input line_number, input line_length, input indent,
                  output ready);
endinterface

// ===== rtl/core/glac_parser.sv =====
// Per-line parse state and the single-byte update that yields at most one item.
module glac_parser #(
  parameter int unsigned LINE_BYTES = glac_pkg::LINE_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             top_i,
  input  logic             req_sum_i,
  output logic             res_valid_o,
  output glac_pkg::res_t   res_o
);
  import glac_pkg::*;

  localparam int unsigned KW = $clog2(LINE_BYTES + 1);
  localparam logic [KW-1:0] KEPT_MAX = KW'(LINE_BYTES);

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_NUMBER  = 3'd1,
    PH_SPACE   = 3'd2,
    PH_CODE    = 3'd3,
    PH_COMMENT = 3'd4,
    PH_QUOTE   = 3'd5,
    PH_SUM     = 3'd6,
    PH_DISCARD = 3'd7
  } phase_e;

  phase_e       phase_q, phase_d;
  logic [KW-1:0] kept_q, kept_d;
  logic [7:0]   xor_q, xor_d;
  logic [8:0]   decl_q, decl_d;
  logic [31:0]  num_q, num_d;
  logic         saw_num_q, saw_num_d;
  logic         saw_sum_q, saw_sum_d;
  logic [7:0]   indent_q, indent_d;
  logic [31:0]  line_cnt_q, line_cnt_d;

  logic         is_eol, is_ws, is_digit, is_n;
  phase_e       eff;
  logic [3:0]   digit;
  logic [11:0]  decl_next;
  logic         do_store, clear;
  logic         bad, missing;
  verdict_e     verd;
  logic [31:0]  verd_num;

  assign is_eol   = (byte_i == CH_NUL) || (byte_i == CH_LF) || (byte_i == CH_CR);
  assign is_ws    = (byte_i == CH_SPACE) || (byte_i == CH_TAB);
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_n     = (byte_i == CH_UPPER_N) || (byte_i == CH_LOWER_N);
  assign digit    = byte_i[3:0];
  assign decl_next = {decl_q, 3'b000} + {2'b00, decl_q, 1'b0} + {8'd0, digit};

  always_comb begin
    phase_d    = phase_q;
    kept_d     = kept_q;
    xor_d      = xor_q;
    decl_d     = decl_q;
    num_d      = num_q;
    saw_num_d  = saw_num_q;
    saw_sum_d  = saw_sum_q;
    indent_d   = indent_q;
    line_cnt_d = line_cnt_q;
    res_valid_o = 1'b0;
    res_o      = '0;
    do_store   = 1'b0;
    clear      = 1'b0;
    eff        = phase_q;
    bad        = saw_sum_q && ({1'b0, xor_q} != decl_q);
    missing    = req_sum_i && !saw_sum_q && top_i;
    verd       = VERD_ACCEPT;
    verd_num   = saw_num_q ? num_q : line_cnt_q;

    if (is_eol) begin
      clear = 1'b1;
      if (kept_q != '0) begin
        if (kept_q >= KEPT_MAX) begin
          verd = VERD_OVERFLOW;
        end else if (bad) begin
          verd = saw_num_q ? VERD_RESEND : VERD_BAD_SUM;
        end else if (missing) begin
          verd = VERD_MISSING;
        end else begin
          verd = VERD_ACCEPT;
        end
        if (verd == VERD_ACCEPT || verd == VERD_RESEND) begin
          line_cnt_d = saw_num_q ? num_q : line_cnt_q + 32'd1;
          verd_num   = line_cnt_d;
        end
        res_valid_o       = 1'b1;
        res_o.item_kind   = KIND_VERDICT;
        res_o.verdict     = verd;
        res_o.line_number = verd_num;
        res_o.line_length = 9'(kept_q);
        res_o.indent      = indent_q;
      end
    end else begin
      if (byte_i == CH_ERROR && phase_q != PH_DISCARD) begin
        kept_d = '0;
        eff    = PH_DISCARD;
      end
      if (eff == PH_START && !is_n && !is_ws) begin
        eff = PH_CODE;
      end
      if (eff == PH_NUMBER && !is_digit) begin
        eff = is_ws ? PH_SPACE : PH_CODE;
      end
      if (eff == PH_SPACE && !is_ws) begin
        eff = PH_CODE;
      end
      phase_d = eff;
      unique case (eff)
        PH_START: begin
          xor_d = xor_q ^ byte_i;
          if (is_n) begin
            saw_num_d = 1'b1;
            num_d     = '0;
            phase_d   = PH_NUMBER;
          end else if (indent_q != 8'hFF) begin
            indent_d = indent_q + 8'd1;
          end
        end
        PH_NUMBER: begin
          xor_d = xor_q ^ byte_i;
          num_d = {num_q[28:0], 3'b000} + {num_q[30:0], 1'b0} + {28'd0, digit};
        end
        PH_SPACE: begin
          xor_d = xor_q ^ byte_i;
        end
        PH_CODE: begin
          if (byte_i == CH_STAR) begin
            decl_d    = '0;
            saw_sum_d = 1'b1;
            phase_d   = PH_SUM;
          end else if (byte_i == CH_SEMI) begin
            phase_d = PH_DISCARD;
          end else if (byte_i == CH_LPAREN) begin
            xor_d   = xor_q ^ byte_i;
            phase_d = PH_COMMENT;
          end else begin
            do_store = 1'b1;
            if (byte_i == CH_QUOTE) begin
              phase_d = PH_QUOTE;
            end
          end
        end
        PH_COMMENT: begin
          xor_d = xor_q ^ byte_i;
          if (byte_i == CH_RPAREN) begin
            phase_d = PH_CODE;
          end
        end
        PH_QUOTE: begin
          do_store = 1'b1;
          if (byte_i == CH_QUOTE) begin
            phase_d = PH_CODE;
          end
        end
        PH_SUM: begin
          if (is_digit) begin
            decl_d = (decl_next > 12'(DECL_SUM_MAX)) ? DECL_SUM_MAX : decl_next[8:0];
          end else begin
            phase_d = PH_DISCARD;
          end
        end
        PH_DISCARD: begin
        end
        default: begin
        end
      endcase
      if (do_store) begin
        xor_d = xor_q ^ byte_i;
        if (kept_q < KEPT_MAX) begin
          res_valid_o         = 1'b1;
          res_o.item_kind     = KIND_CHAR;
          res_o.char_value    = byte_i;
          res_o.char_position = 8'(kept_q);
          kept_d              = kept_q + KW'(1);
        end
      end
    end

    if (clear) begin
      phase_d   = PH_START;
      kept_d    = '0;
      xor_d     = '0;
      decl_d    = '0;
      num_d     = '0;
      saw_num_d = 1'b0;
      saw_sum_d = 1'b0;
      indent_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      kept_q     <= '0;
      xor_q      <= '0;
      decl_q     <= '0;
      num_q      <= '0;
      saw_num_q  <= 1'b0;
      saw_sum_q  <= 1'b0;
      indent_q   <= '0;
      line_cnt_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      kept_q     <= kept_d;
      xor_q      <= xor_d;
      decl_q     <= decl_d;
      num_q      <= num_d;
      saw_num_q  <= saw_num_d;
      saw_sum_q  <= saw_sum_d;
      indent_q   <= indent_d;
      line_cnt_q <= line_cnt_d;
    end
  end

endmodule

// ===== rtl/core/gcode_line_assembler_checksum_top.sv =====
// Top level of the G-code line assembler: input register, parser, result register.
//
//   channel   dir   handshake       payload
//   in_i      in    valid/ready     rx_byte, top_level
//   out_o     out   valid/ready     item_kind, char_value, char_position, verdict,
//                                   line_number, line_length, indent
//   cfg       in    cfg_we_i        cfg_wdata_i (require_checksum)
//
// One byte per cycle sustained while the output is not stalled; a byte is held in
// the input register and, when it advances, its item (if any) is registered into the
// result register. The parse update is combinational logic between the two registers.
// Reset clears all line state, the line counter and require_checksum. A stalled output
// holds; the input register keeps filling while the result register is free or being taken.
module gcode_line_assembler_checksum_top #(
  parameter int unsigned LINE_BYTES = glac_pkg::LINE_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  glac_in_if.sink      in_i,
  glac_out_if.source   out_o
);
  import glac_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_top_q;
  logic       out_vld_q;
  res_t       out_q;
  logic       req_sum_q;
  logic       advance;
  logic       res_valid;
  res_t       res;

  assign advance  = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  glac_parser #(
    .LINE_BYTES (LINE_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .top_i       (in_top_q),
    .req_sum_i   (req_sum_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_sum_q <= 1'b0;
    end else if (cfg_we_i) begin
      req_sum_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.rx_byte;
      in_top_q  <= in_i.top_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res_valid;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.item_kind     = out_q.item_kind;
  assign out_o.char_value    = out_q.char_value;
  assign out_o.char_position = out_q.char_position;
  assign out_o.verdict       = out_q.verdict;
  assign out_o.line_number   = out_q.line_number;
  assign out_o.line_length   = out_q.line_length;
  assign out_o.indent        = out_q.indent;

endmodule
